>>> rtl/qed_pkg.sv
// Package for the quadrature encoder decoder: direction codes, config layout,
// stream widths and the full-step and half-step transition tables.
// No dependencies.
`default_nettype none

package qed_pkg;

    // Detent direction reported with every result
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    // One table entry: direction reported and the next step state
    typedef struct packed {
        dir_t       dir;
        logic [2:0] next_state;
    } step_entry_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_STEP_MODE  = 1'b0,
        REG_TIMEOUT_MS = 1'b1
    } reg_index_t;

    localparam int unsigned TIMEOUT_W          = 32;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd100;
    localparam int unsigned NOW_W              = 32;
    localparam int unsigned DEFAULT_TIME_WIDTH = 32;

    // Stream payload layout
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 8;
    localparam int unsigned S_CLOCK_BIT = 0;
    localparam int unsigned S_DATA_BIT  = 1;
    localparam int unsigned S_NOW_LSB   = 2;

    // Configuration registers as seen by the decoder
    typedef struct packed {
        logic                 step_mode;
        logic [TIMEOUT_W-1:0] timeout_ms;
    } qed_cfg_t;

    // Full-step table, indexed [state][{data, clock}]
    localparam step_entry_t FULL_TAB [8][4] = '{
        '{'{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd4}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd1}, '{DIR_CW,   3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd1}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd6}, '{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd4}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd6}, '{DIR_NONE, 3'd5}, '{DIR_NONE, 3'd0}, '{DIR_CCW,  3'd0}},
        '{'{DIR_NONE, 3'd6}, '{DIR_NONE, 3'd5}, '{DIR_NONE, 3'd4}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd4}, '{DIR_NONE, 3'd0}}
    };

    // Half-step table; unused states fall back to the start row
    localparam step_entry_t HALF_TAB [8][4] = '{
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd1}, '{DIR_NONE, 3'd0}},
        '{'{DIR_CCW,  3'd3}, '{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd1}, '{DIR_NONE, 3'd0}},
        '{'{DIR_CW,   3'd3}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd5}, '{DIR_NONE, 3'd4}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd4}, '{DIR_CW,   3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd5}, '{DIR_NONE, 3'd3}, '{DIR_CCW,  3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd1}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd1}, '{DIR_NONE, 3'd0}}
    };

endpackage

`default_nettype wire

>>> rtl/qed_core.sv
// Decoder core: step state, detent timestamp and timeout flag, updated once
// per accepted sample. Depends on qed_pkg.
`default_nettype none

module qed_core #(
    parameter int unsigned TIME_WIDTH = qed_pkg::DEFAULT_TIME_WIDTH
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire qed_pkg::qed_cfg_t         cfg,
    input  wire logic                      accept,
    input  wire logic                      clock_level,
    input  wire logic                      data_level,
    input  wire logic [qed_pkg::NOW_W-1:0] now_ms,
    output qed_pkg::dir_t                  direction
);
    import qed_pkg::*;

    localparam int unsigned CMP_W = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;

    logic [2:0]            step_state_reg, step_state_next;
    logic [TIME_WIDTH-1:0] detent_time_reg, detent_time_next;
    logic                  timeout_armed_reg, timeout_armed_next;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  expired;
    logic [1:0]            code;
    step_entry_t           entry;

    // Elapsed time since the last detent, wrapping at the time width
    assign now_t   = TIME_WIDTH'(now_ms);
    assign elapsed = now_t - detent_time_reg;
    assign expired = timeout_armed_reg && (CMP_W'(elapsed) > CMP_W'(cfg.timeout_ms));

    // Look up the transition for the current pin code
    assign code  = {data_level, clock_level};
    assign entry = cfg.step_mode ? HALF_TAB[step_state_reg][code]
                                 : FULL_TAB[step_state_reg][code];

    // Next state and direction
    always_comb
    begin
        step_state_next    = step_state_reg;
        detent_time_next   = detent_time_reg;
        timeout_armed_next = timeout_armed_reg;
        direction          = DIR_NONE;
        if (expired)
        begin
            // drop this sample and disarm the timeout
            timeout_armed_next = 1'b0;
            detent_time_next   = '0;
        end
        else
        begin
            step_state_next = entry.next_state;
            direction       = entry.dir;
            if (entry.dir == DIR_CW || entry.dir == DIR_CCW)
            begin
                detent_time_next   = now_t;
                timeout_armed_next = 1'b1;
            end
        end
    end

    // Advance state on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_state_reg    <= 3'd0;
            detent_time_reg   <= '0;
            timeout_armed_reg <= 1'b0;
        end
        else if (accept)
        begin
            step_state_reg    <= step_state_next;
            detent_time_reg   <= detent_time_next;
            timeout_armed_reg <= timeout_armed_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/quadrature_encoder_decoder.sv
// Top level of the quadrature encoder decoder: config registers, decoder core
// and a two-entry result queue. Depends on qed_pkg and qed_core.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------
//   s_*      | in        | s_tvalid / s_tready  | clock_level, data_level, now_ms
//   m_*      | out       | m_tvalid / m_tready  | direction
//   cfg_*    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One sample per clock while s_tready is high; each sample yields one direction
// result queued the cycle after acceptance. The combinational table lookup
// and timeout compare set the rate. The two-entry result queue keeps s_tready
// high while one result waits; s_tready drops only when both entries are held
// by a stalled m_tready. Reset returns to the start state, timeout disarmed,
// full-step mode and a 100 ms timeout. Config writes are always taken.
`default_nettype none

module quadrature_encoder_decoder #(
    parameter int unsigned TIME_WIDTH = qed_pkg::DEFAULT_TIME_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [0] clock_level, [1] data_level, [33:2] now_ms, [39:34] zero
    input  wire logic [qed_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] direction, [7:2] zero
    output logic [qed_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [qed_pkg::TIMEOUT_W-1:0] cfg_data
);
    import qed_pkg::*;

    qed_cfg_t   cfg_reg;
    logic       in_accept;
    logic       out_pop;
    dir_t       dir_new;
    logic [1:0] cnt_reg, cnt_next;
    dir_t       head_reg, head_next;
    dir_t       tail_reg, tail_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = (cnt_reg != 2'd2);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign out_pop   = m_tvalid && m_tready;
    assign m_tdata   = M_TDATA_W'(head_reg);

    // Hold config registers, write on request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_mode  <= 1'b0;
            cfg_reg.timeout_ms <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_STEP_MODE:  cfg_reg.step_mode  <= cfg_data[0];
                REG_TIMEOUT_MS: cfg_reg.timeout_ms <= cfg_data;
                default:        ;
            endcase
        end
    end

    qed_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (in_accept),
        .clock_level (s_tdata[S_CLOCK_BIT]),
        .data_level  (s_tdata[S_DATA_BIT]),
        .now_ms      (s_tdata[S_NOW_LSB +: NOW_W]),
        .direction   (dir_new)
    );

    // Result queue: push decoded direction, pop on output request
    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        priority case (1'b1)
            (in_accept && out_pop):
            begin
                if (cnt_reg == 2'd1)
                    head_next = dir_new;
                else
                begin
                    head_next = tail_reg;
                    tail_next = dir_new;
                end
            end
            in_accept:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0)
                    head_next = dir_new;
                else
                    tail_next = dir_new;
            end
            out_pop:
            begin
                cnt_next  = cnt_reg - 2'd1;
                head_next = tail_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

>>> rtl/qed_checker.sv
// Port-level checks for the quadrature encoder decoder, bound to the top level.
// Depends on qed_pkg and quadrature_encoder_decoder.
`default_nettype none

module qed_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [qed_pkg::M_TDATA_W-1:0] m_tdata
);
    import qed_pkg::*;

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Each accepted sample leaves a result pending the next cycle
    a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted sample produced no result");

    // Back-pressure only while results are waiting
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Direction code is legal and padding is zero
    a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == DIR_NONE || m_tdata[1:0] == DIR_CW
                      || m_tdata[1:0] == DIR_CCW) && (m_tdata[7:2] == 6'd0))
        else $error("illegal direction code on output");

endmodule

bind quadrature_encoder_decoder qed_checker u_qed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the quadrature encoder decoder: streams pin samples
// with timestamps, predicts every direction result and checks it in order.
// Depends on qed_pkg and the quadrature_encoder_decoder top level.

module tb;

    import qed_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned PHASE_ITEMS = 105;

    // Next step state, indexed [state][{data, clock}]
    localparam logic [2:0] FULL_NEXT [8][4] = '{
        '{3'd0, 3'd2, 3'd4, 3'd0},
        '{3'd3, 3'd0, 3'd1, 3'd0},
        '{3'd3, 3'd2, 3'd0, 3'd0},
        '{3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd6, 3'd0, 3'd4, 3'd0},
        '{3'd6, 3'd5, 3'd0, 3'd0},
        '{3'd6, 3'd5, 3'd4, 3'd0},
        '{3'd0, 3'd2, 3'd4, 3'd0}
    };
    localparam logic [2:0] HALF_NEXT [8][4] = '{
        '{3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd3, 3'd0, 3'd1, 3'd0},
        '{3'd3, 3'd2, 3'd0, 3'd0},
        '{3'd3, 3'd5, 3'd4, 3'd0},
        '{3'd3, 3'd3, 3'd4, 3'd0},
        '{3'd3, 3'd5, 3'd3, 3'd0},
        '{3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd3, 3'd2, 3'd1, 3'd0}
    };

    // Pin codes {data, clock} of one detent, starting from rest at 11
    localparam logic [1:0] CW_SEQ  [4] = '{2'd1, 2'd0, 2'd2, 2'd3};
    localparam logic [1:0] CCW_SEQ [4] = '{2'd2, 2'd0, 2'd1, 2'd3};

    // Detent tracker: mirrors the decoder state and queues the expected directions
    class direction_scoreboard;
        bit          half_mode;
        logic [31:0] timeout_ms;
        logic [2:0]  step_state;
        logic [31:0] detent_ms;
        bit          armed;
        dir_t        expected_dirs [$];
        int unsigned errors;
        int unsigned samples;
        int unsigned results;
        int unsigned cw_count;
        int unsigned ccw_count;
        int unsigned discards;

        function new();
            half_mode  = 1'b0;
            timeout_ms = 32'd100;
            step_state = 3'd0;
            detent_ms  = 32'd0;
            armed      = 1'b0;
        endfunction

        function void set_register(reg_index_t idx, logic [31:0] value);
            if (idx == REG_STEP_MODE)
                half_mode = value[0];
            else
                timeout_ms = value;
        endfunction

        function dir_t detent_dir(logic [2:0] st, logic [1:0] code);
            case ({half_mode, st, code})
                6'b0_001_11: return DIR_CW;
                6'b0_101_11: return DIR_CCW;
                6'b1_001_00: return DIR_CCW;
                6'b1_010_00: return DIR_CW;
                6'b1_100_11: return DIR_CW;
                6'b1_101_11: return DIR_CCW;
                default:     return DIR_NONE;
            endcase
        endfunction

        // Advance the decoder state by one accepted request
        function void note_sample(bit clock_level, bit data_level, logic [31:0] now_ms);
            logic [1:0]  code;
            logic [31:0] elapsed;
            dir_t        dir;
            code = {data_level, clock_level};
            samples++;
            if (armed) begin
                elapsed = now_ms - detent_ms;
                if (elapsed > timeout_ms) begin
                    // Drop this sample: keep the step state and disarm
                    armed     = 1'b0;
                    detent_ms = 32'd0;
                    discards++;
                    expected_dirs.push_back(DIR_NONE);
                    return;
                end
            end
            dir        = detent_dir(step_state, code);
            step_state = half_mode ? HALF_NEXT[step_state][code] : FULL_NEXT[step_state][code];
            if (dir != DIR_NONE) begin
                detent_ms = now_ms;
                armed     = 1'b1;
                if (dir == DIR_CW)
                    cw_count++;
                else
                    ccw_count++;
            end
            expected_dirs.push_back(dir);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR: %s", msg);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] tdata);
            dir_t want;
            results++;
            if (expected_dirs.size() == 0) begin
                report($sformatf("result %0d (direction %0d) with nothing expected",
                                 results, tdata[1:0]));
                return;
            end
            want = expected_dirs.pop_front();
            if (tdata[1:0] !== want)
                report($sformatf("result %0d: direction expected %0d, got %0d",
                                 results, want, tdata[1:0]));
        endfunction

        function int unsigned pending();
            return expected_dirs.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [0:0]           cfg_index = REG_STEP_MODE;
    logic [31:0]          cfg_data = '0;

    direction_scoreboard sb;
    logic [31:0]         now_cur;
    bit                  tx_quiet;
    int unsigned         cycle_count;
    int unsigned         rx_stall_left;
    int unsigned         rx_stretch_left;
    bit                  rx_quiet;
    int unsigned         phase_count;

    quadrature_encoder_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Check accepted results, then pick the ready level for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (rx_stretch_left == 0)
        begin
            rx_quiet        = ($urandom_range(0, 3) == 0);
            rx_stretch_left = $urandom_range(20, 80);
        end
        else
            rx_stretch_left--;
        if (rx_stall_left != 0)
        begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end
        else if (!rx_quiet && $urandom_range(0, 99) < 15)
        begin
            rx_stall_left = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2)
                                                        : $urandom_range(10, 40);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Time step to the next sample, weighted around the current timeout
    function automatic logic [31:0] pick_delta();
        int unsigned r;
        logic [31:0] span;
        r    = $urandom_range(0, 99);
        span = (sb.timeout_ms > 32'd400) ? 32'd400 : sb.timeout_ms;
        if (r < 55)
            return $urandom_range(0, 3);
        if (r < 80)
            return $urandom_range(0, span + 2);
        if (r < 88)
            return sb.timeout_ms;
        if (r < 95)
            return sb.timeout_ms + 32'd1;
        return $urandom;
    endfunction

    // Send one request and hold it until it is taken
    task automatic send_sample(bit clock_level, bit data_level, logic [31:0] now_ms);
        logic [S_TDATA_W-1:0] payload;
        int unsigned          gap;
        payload                      = '0;
        payload[S_CLOCK_BIT]         = clock_level;
        payload[S_DATA_BIT]          = data_level;
        payload[S_NOW_LSB +: NOW_W]  = now_ms;
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(clock_level, data_level, now_ms);
        gap = pick_gap(tx_quiet);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_at(logic [1:0] code, logic [31:0] now_ms);
        now_cur = now_ms;
        send_sample(code[0], code[1], now_ms);
    endtask

    task automatic send_code(logic [1:0] code);
        send_at(code, now_cur + pick_delta());
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Turn the knob through several detents, with occasional contact bounce
    task automatic turn(bit ccw, int unsigned detents);
        logic [1:0] code;
        logic [1:0] prev;
        prev = 2'd3;
        repeat (detents)
        begin
            for (int k = 0; k < 4; k++)
            begin
                code = ccw ? CCW_SEQ[k] : CW_SEQ[k];
                send_code(code);
                if ($urandom_range(0, 99) < 8)
                begin
                    send_code(prev);
                    send_code(code);
                end
                prev = code;
            end
        end
    endtask

    task automatic run_phase(bit half, logic [31:0] tmo);
        int unsigned target;
        int unsigned r;
        wait_idle();
        write_reg(REG_STEP_MODE, {31'($urandom_range(0, 32'h7fff_ffff)), half});
        write_reg(REG_TIMEOUT_MS, tmo);
        phase_count++;
        target = sb.samples + PHASE_ITEMS;
        while (sb.samples < target)
        begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            r        = $urandom_range(0, 99);
            if (r < 70)
                turn(1'($urandom_range(0, 1)), $urandom_range(1, 3));
            else if (r < 85)
            begin
                // Noise: random pin codes
                repeat ($urandom_range(1, 6))
                    send_code(2'($urandom_range(0, 3)));
            end
            else
            begin
                // Broken detent: stop partway through
                bit          ccw;
                int unsigned steps;
                ccw   = 1'($urandom_range(0, 1));
                steps = $urandom_range(1, 3);
                for (int k = 0; k < steps; k++)
                    send_code(ccw ? CCW_SEQ[k] : CW_SEQ[k]);
            end
            if ($urandom_range(0, 99) < 4)
                wait_idle();
        end
    endtask

    initial
    begin
        sb       = new();
        now_cur  = '0;
        tx_quiet = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(REG_STEP_MODE, 32'd0);
        write_reg(REG_TIMEOUT_MS, 32'd100);

        // Full step: clockwise detent landing on time zero, then timeout boundary
        send_at(2'd1, 32'hffff_fffd);
        send_at(2'd0, 32'hffff_fffe);
        send_at(2'd2, 32'hffff_ffff);
        send_at(2'd3, 32'd0);
        send_at(2'd3, 32'd100);
        send_at(2'd3, 32'd101);
        send_at(2'd3, 32'd5000);
        // Counter-clockwise detent, then a discard in the middle of a turn
        send_at(2'd2, 32'd5001);
        send_at(2'd0, 32'd5002);
        send_at(2'd1, 32'd5003);
        send_at(2'd3, 32'd5004);
        send_at(2'd1, 32'd5104);
        send_at(2'd0, 32'd5105);
        send_at(2'd0, 32'd5106);
        send_at(2'd3, 32'd5107);
        // Park in the ccw-next state before the switch to half step
        send_at(2'd2, 32'd5108);
        send_at(2'd0, 32'd5109);
        wait_idle();
        write_reg(REG_STEP_MODE, 32'd1);

        // Half step: leftover state acts as start; elapsed time wraps past zero
        send_at(2'd1, 32'd5110);
        send_at(2'd0, 32'hffff_fff0);
        send_at(2'd2, 32'h0000_0050);
        send_at(2'd3, 32'h0000_0055);
        send_at(2'd3, 32'h0000_0056);
        send_at(2'd2, 32'h0000_0057);
        send_at(2'd0, 32'h0000_0058);
        send_at(2'd1, 32'h0000_0059);
        send_at(2'd3, 32'h0000_005a);

        // Random phases across both tables and the timeout extremes
        run_phase(1'b0, 32'd0);
        run_phase(1'b1, 32'hffff_ffff);
        run_phase(1'b0, $urandom_range(1, 50));
        run_phase(1'b1, 32'd100);
        run_phase(1'b1, 32'd0);
        run_phase(1'b0, 32'hffff_ffff);
        run_phase(1'b1, $urandom_range(1, 1000));
        run_phase(1'b0, 32'd100);

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        $display("Decoded %0d samples over %0d settings: %0d cw and %0d ccw detents,",
                 sb.samples, phase_count + 2, sb.cw_count, sb.ccw_count);
        $display("%0d timeout discards, %0d results checked, %0d errors",
                 sb.discards, sb.results, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
